// ===== sv/xbt_pkg.sv =====
// Shared types, codes and constant tables of the XML byte tokenizer.
`default_nettype none
package xbt_pkg;

    localparam int LINE_W = 20;
    localparam int COL_W  = 16;
    localparam logic [LINE_W-1:0] LINE_SAT = '1;
    localparam logic [COL_W-1:0]  COL_SAT  = '1;

    typedef enum logic [4:0] {
        S_IDLE, S_LT, S_QUEST, S_QUEST2, S_START, S_ATT, S_ATTNAME, S_ATTEQ,
        S_ATTVAL, S_SELF, S_CONTENT, S_END, S_NEWTAG, S_EXCL, S_EXCLMIN,
        S_COMMENT, S_MIN, S_MIN2, S_CDSTART, S_CDATA, S_CDEND, S_CDEND2, S_HALT
    } parse_state_t;

    typedef enum logic [3:0] {
        EV_NAME, EV_ATTR_NAME, EV_ATTR_VAL, EV_TEXT, EV_START_DONE,
        EV_END_ELEM, EV_TEXT_END, EV_ERROR, EV_DOC_END
    } ev_kind_t;

    typedef enum logic [3:0] {
        ERR_NONE, ERR_OUTSIDE, ERR_PROLOG, ERR_NO_NAME, ERR_ATTR, ERR_SLASH,
        ERR_ENTITY, ERR_MISMATCH, ERR_COMMENT, ERR_CDATA, ERR_CAPACITY
    } err_code_t;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_EXCL  = 8'h21;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_RBRK  = 8'h5D;

    // Entity names after the ampersand, first character in the lowest byte.
    localparam int ENT_NUM = 5;
    localparam logic [39:0] ENT_PAT [ENT_NUM] = '{
        40'h00_3B_70_6D_61, 40'h00_00_3B_74_67, 40'h00_00_3B_74_6C,
        40'h3B_74_6F_75_71, 40'h3B_73_6F_70_61
    };
    localparam logic [2:0] ENT_LEN [ENT_NUM] = '{3'd4, 3'd3, 3'd3, 3'd5, 3'd5};
    localparam logic [7:0] ENT_VAL [ENT_NUM] = '{8'h26, 8'h3E, 8'h3C, 8'h22, 8'h27};

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [LINE_W-1:0] line;
        logic [4:0]        depth;
        err_code_t         err;
        logic [7:0]        data;
        ev_kind_t          kind;
    } res_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_LF) || (c == CH_TAB) || (c == CH_CR);
    endfunction

    function automatic res_t mk_res(input ev_kind_t kind, input logic [7:0] data,
                                    input err_code_t err, input logic [4:0] depth,
                                    input logic [LINE_W-1:0] line,
                                    input logic [COL_W-1:0] col);
        res_t r;
        r.kind  = kind;
        r.data  = data;
        r.err   = err;
        r.depth = depth;
        r.line  = line;
        r.col   = col;
        return r;
    endfunction

    function automatic logic [63:0] pack_res(input res_t r);
        return {7'd0, r};
    endfunction

endpackage
`default_nettype wire

// ===== sv/xbt_name_store.sv =====
// Name stack memory and saved name lengths with registered, prefetched reads.
`default_nettype none
module xbt_name_store #(
    parameter int AW = 9,
    parameter int DW = 4,
    parameter int LW = 6
) (
    input  wire logic          clk,
    input  wire logic          stk_we,
    input  wire logic [AW-1:0] stk_waddr,
    input  wire logic [7:0]    stk_wdata,
    input  wire logic [AW-1:0] stk_raddr,
    output logic      [7:0]    stk_rdata,
    input  wire logic          len_we,
    input  wire logic [DW-1:0] len_waddr,
    input  wire logic [LW-1:0] len_wdata,
    input  wire logic [DW-1:0] len_raddr,
    output logic      [LW-1:0] len_rdata
);
    logic [7:0]    stk_mem [2**AW];
    logic [LW-1:0] len_mem [2**DW];

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        stk_rdata <= stk_mem[stk_raddr];
    end

    // A length saved in the same cycle as it is fetched is forwarded.
    always_ff @(posedge clk)
    begin
        if (len_we)
        begin
            len_mem[len_waddr] <= len_wdata;
        end
        if (len_we && (len_waddr == len_raddr))
        begin
            len_rdata <= len_wdata;
        end
        else
        begin
            len_rdata <= len_mem[len_raddr];
        end
    end
endmodule
`default_nettype wire

// ===== sv/xbt_parser.sv =====
// Tokenizer state machine: one byte in, up to two results out per cycle while take is high.
`default_nettype none
module xbt_parser #(
    parameter int MAX_DEPTH = 16,
    parameter int MAX_NAME  = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        take,
    input  wire logic [7:0]  byte_in,
    output xbt_pkg::res_t    res0,
    output xbt_pkg::res_t    res1,
    output logic [1:0]       res_cnt
);
    import xbt_pkg::*;

    localparam int NW  = $clog2(MAX_DEPTH + 1);
    localparam int DW  = (MAX_DEPTH > 2) ? $clog2(MAX_DEPTH) : 1;
    localparam int LW  = $clog2(MAX_NAME + 1);
    localparam int NAW = $clog2(MAX_NAME);
    localparam int AW  = $clog2(MAX_DEPTH * MAX_NAME);
    localparam logic [NW-1:0] DEPTH_FULL = NW'(MAX_DEPTH);
    localparam logic [LW-1:0] NAME_FULL  = LW'(MAX_NAME);
    localparam logic [AW-1:0] ROW        = AW'(MAX_NAME);

    parse_state_t      state_reg, state_next;
    logic [NW-1:0]     nest_reg, nest_next;
    logic [LW-1:0]     top_len_reg, top_len_next;
    logic [LW-1:0]     idx_reg, idx_next;
    logic              mism_reg, mism_next;
    logic              ent_open_reg, ent_open_next;
    logic [2:0]        ent_cnt_reg, ent_cnt_next;
    logic [4:0]        ent_mask_reg, ent_mask_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [COL_W-1:0]  col_reg, col_next;

    logic [LINE_W-1:0] upd_line;
    logic [COL_W-1:0]  upd_col;
    logic [7:0]        c;
    logic [DW-1:0]     top_idx;
    logic              open_bad, open_full, name_full, end_ok, end_match;
    logic [4:0]        ent_mask_new, ent_done;
    logic              ent_any, ent_hit;
    logic [7:0]        ent_char;
    logic [4:0]        d_now, d_up, d_down;

    logic              stk_we, len_we;
    logic [AW-1:0]     stk_waddr, stk_raddr;
    logic [DW-1:0]     len_raddr;
    logic [7:0]        stk_rdata;
    logic [LW-1:0]     len_rdata;
    logic [NW-1:0]     nest_eff;
    logic [LW-1:0]     idx_eff;
    logic [NAW-1:0]    idx_clamp;

    assign c         = byte_in;
    assign top_idx   = DW'(nest_reg - NW'(1));
    assign open_bad  = (c == CH_GT) || is_ws(c);
    assign open_full = nest_reg >= DEPTH_FULL;
    assign name_full = top_len_reg >= NAME_FULL;
    assign end_ok    = !mism_reg && (idx_reg == top_len_reg);
    assign end_match = !mism_reg && (idx_reg < top_len_reg) && (idx_reg < NAME_FULL)
                       && (stk_rdata == c);
    assign d_now     = 5'(nest_reg);
    assign d_up      = 5'(nest_reg + NW'(1));
    assign d_down    = (nest_reg != '0) ? 5'(nest_reg - NW'(1)) : 5'd0;

    always_comb
    begin
        upd_col  = (col_reg < COL_SAT) ? col_reg + COL_W'(1) : col_reg;
        upd_line = line_reg;
        if (c == CH_LF)
        begin
            upd_col  = COL_W'(1);
            upd_line = (line_reg < LINE_SAT) ? line_reg + LINE_W'(1) : line_reg;
        end
    end

    // Entity prefix match: one candidate bit per known entity.
    always_comb
    begin
        for (int k = 0; k < ENT_NUM; k++)
        begin
            ent_mask_new[k] = ent_mask_reg[k] && (ent_cnt_reg < ENT_LEN[k])
                              && (ENT_PAT[k][8*ent_cnt_reg +: 8] == c);
            ent_done[k]     = ent_mask_new[k] && (3'(ent_cnt_reg + 3'd1) == ENT_LEN[k]);
        end
        ent_any  = |ent_mask_new;
        ent_hit  = |ent_done;
        ent_char = 8'd0;
        for (int k = ENT_NUM - 1; k >= 0; k--)
        begin
            if (ent_done[k])
            begin
                ent_char = ENT_VAL[k];
            end
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        if (c == CH_NUL)
        begin
            state_next = S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (c == CH_LT) state_next = S_LT;
                    else if (!is_ws(c)) state_next = S_HALT;
                end
                S_LT, S_NEWTAG:
                begin
                    if (c == CH_SLASH) state_next = S_END;
                    else if (c == CH_EXCL) state_next = S_EXCL;
                    else if ((c == CH_QUEST) && (state_reg == S_LT)) state_next = S_QUEST;
                    else if (open_bad || open_full) state_next = S_HALT;
                    else state_next = S_START;
                end
                S_QUEST:   if (c == CH_QUEST) state_next = S_QUEST2;
                S_QUEST2:  state_next = (c == CH_GT) ? S_IDLE : S_HALT;
                S_START:
                begin
                    if (c == CH_SLASH) state_next = S_SELF;
                    else if (c == CH_GT) state_next = S_CONTENT;
                    else if (is_ws(c)) state_next = S_ATT;
                    else if ((nest_reg == '0) || name_full) state_next = S_HALT;
                end
                S_ATT:
                begin
                    if (is_ws(c)) state_next = S_ATT;
                    else if (c == CH_GT) state_next = S_CONTENT;
                    else if (c == CH_SLASH) state_next = S_SELF;
                    else state_next = S_ATTNAME;
                end
                S_ATTNAME: if (c == CH_EQ) state_next = S_ATTEQ;
                S_ATTEQ:   state_next = (c == CH_QUOTE) ? S_ATTVAL : S_HALT;
                S_ATTVAL:  if (c == CH_QUOTE) state_next = S_ATT;
                S_SELF:    state_next = (c == CH_GT) ? S_IDLE : S_HALT;
                S_CONTENT:
                begin
                    if (c == CH_LT) state_next = ent_open_reg ? S_HALT : S_NEWTAG;
                    else if (ent_open_reg && !ent_hit && !ent_any) state_next = S_HALT;
                end
                S_END:
                begin
                    if (c == CH_GT)
                    begin
                        state_next = ((nest_reg != '0) && end_ok) ? S_IDLE : S_HALT;
                    end
                end
                S_EXCL:
                begin
                    if (c == CH_LBRK) state_next = S_CDSTART;
                    else if (c == CH_MINUS) state_next = S_EXCLMIN;
                end
                S_EXCLMIN: state_next = (c == CH_MINUS) ? S_COMMENT : S_HALT;
                S_COMMENT: if (c == CH_MINUS) state_next = S_MIN;
                S_MIN:     state_next = (c == CH_MINUS) ? S_MIN2 : S_HALT;
                S_MIN2:    state_next = (c == CH_GT) ? S_IDLE : S_HALT;
                S_CDSTART: if (c == CH_LBRK) state_next = S_CDATA;
                S_CDATA:   if (c == CH_RBRK) state_next = S_CDEND;
                S_CDEND:   state_next = (c == CH_RBRK) ? S_CDEND2 : S_HALT;
                S_CDEND2:  state_next = (c == CH_GT) ? S_IDLE : S_HALT;
                S_HALT:    state_next = S_HALT;
                default:   state_next = S_HALT;
            endcase
        end
    end

    // Results, counters, stack and entity state.
    always_comb
    begin
        nest_next     = nest_reg;
        top_len_next  = top_len_reg;
        idx_next      = idx_reg;
        mism_next     = mism_reg;
        ent_open_next = ent_open_reg;
        ent_cnt_next  = ent_cnt_reg;
        ent_mask_next = ent_mask_reg;
        line_next     = line_reg;
        col_next      = col_reg;
        stk_we        = 1'b0;
        stk_waddr     = AW'(top_idx) * ROW + AW'(top_len_reg);
        len_we        = 1'b0;
        res0          = '0;
        res1          = '0;
        res_cnt       = 2'd0;
        if (c == CH_NUL)
        begin
            res0          = mk_res(EV_DOC_END, 8'd0, ERR_NONE, d_now, line_reg, col_reg);
            res_cnt       = 2'd1;
            nest_next     = '0;
            idx_next      = '0;
            mism_next     = 1'b0;
            ent_open_next = 1'b0;
            ent_cnt_next  = '0;
            line_next     = LINE_W'(1);
            col_next      = COL_W'(1);
        end
        else if (state_reg != S_HALT)
        begin
            line_next = upd_line;
            col_next  = upd_col;
            unique case (state_reg)
                S_IDLE:
                begin
                    if ((c != CH_LT) && !is_ws(c))
                    begin
                        res0    = mk_res(EV_ERROR, 8'd0, ERR_OUTSIDE, d_now, upd_line, upd_col);
                        res_cnt = 2'd1;
                    end
                end
                S_LT, S_NEWTAG:
                begin
                    if (c == CH_SLASH)
                    begin
                        idx_next  = '0;
                        mism_next = 1'b0;
                    end
                    else if ((c == CH_EXCL) || ((c == CH_QUEST) && (state_reg == S_LT)))
                    begin
                        res_cnt = 2'd0;
                    end
                    else if (open_bad)
                    begin
                        res0    = mk_res(EV_ERROR, 8'd0, ERR_NO_NAME, d_now, upd_line, upd_col);
                        res_cnt = 2'd1;
                    end
                    else if (open_full)
                    begin
                        res0    = mk_res(EV_ERROR, 8'd0, ERR_CAPACITY, d_now, upd_line, upd_col);
                        res_cnt = 2'd1;
                    end
                    else
                    begin
                        stk_we       = 1'b1;
                        stk_waddr    = AW'(DW'(nest_reg)) * ROW;
                        len_we       = nest_reg != '0;
                        top_len_next = LW'(1);
                        nest_next    = nest_reg + NW'(1);
                        res0         = mk_res(EV_NAME, c, ERR_NONE, d_up, upd_line, upd_col);
                        res_cnt      = 2'd1;
                    end
                end
                S_START, S_ATT:
                begin
                    if (c == CH_SLASH)
                    begin
                        res0         = mk_res(EV_START_DONE, 8'd0, ERR_NONE, d_now,
                                              upd_line, upd_col);
                        res1         = mk_res(EV_END_ELEM, 8'd0, ERR_NONE, d_down,
                                              upd_line, upd_col);
                        res_cnt      = 2'd2;
                        nest_next    = (nest_reg != '0) ? nest_reg - NW'(1) : nest_reg;
                        top_len_next = len_rdata;
                    end
                    else if (c == CH_GT)
                    begin
                        res0          = mk_res(EV_START_DONE, 8'd0, ERR_NONE, d_now,
                                               upd_line, upd_col);
                        res_cnt       = 2'd1;
                        ent_open_next = 1'b0;
                        ent_cnt_next  = '0;
                    end
                    else if (is_ws(c))
                    begin
                        res_cnt = 2'd0;
                    end
                    else if (state_reg == S_ATT)
                    begin
                        res0    = mk_res(EV_ATTR_NAME, c, ERR_NONE, d_now, upd_line, upd_col);
                        res_cnt = 2'd1;
                    end
                    else if (nest_reg == '0)
                    begin
                        res0    = mk_res(EV_ERROR, 8'd0, ERR_NO_NAME, d_now, upd_line, upd_col);
                        res_cnt = 2'd1;
                    end
                    else if (name_full)
                    begin
                        res0    = mk_res(EV_ERROR, 8'd0, ERR_CAPACITY, d_now, upd_line, upd_col);
                        res_cnt = 2'd1;
                    end
                    else
                    begin
                        stk_we       = 1'b1;
                        top_len_next = top_len_reg + LW'(1);
                        res0         = mk_res(EV_NAME, c, ERR_NONE, d_now, upd_line, upd_col);
                        res_cnt      = 2'd1;
                    end
                end
                S_ATTNAME:
                begin
                    if (c != CH_EQ)
                    begin
                        res0    = mk_res(EV_ATTR_NAME, c, ERR_NONE, d_now, upd_line, upd_col);
                        res_cnt = 2'd1;
                    end
                end
                S_ATTVAL:
                begin
                    if (c != CH_QUOTE)
                    begin
                        res0    = mk_res(EV_ATTR_VAL, c, ERR_NONE, d_now, upd_line, upd_col);
                        res_cnt = 2'd1;
                    end
                end
                S_ATTEQ:
                begin
                    if (c != CH_QUOTE)
                    begin
                        res0    = mk_res(EV_ERROR, 8'd0, ERR_ATTR, d_now, upd_line, upd_col);
                        res_cnt = 2'd1;
                    end
                end
                S_SELF:
                begin
                    if (c != CH_GT)
                    begin
                        res0    = mk_res(EV_ERROR, 8'd0, ERR_SLASH, d_now, upd_line, upd_col);
                        res_cnt = 2'd1;
                    end
                end
                S_QUEST2:
                begin
                    if (c != CH_GT)
                    begin
                        res0    = mk_res(EV_ERROR, 8'd0, ERR_PROLOG, d_now, upd_line, upd_col);
                        res_cnt = 2'd1;
                    end
                end
                S_CONTENT:
                begin
                    if (c == CH_LT)
                    begin
                        if (ent_open_reg)
                        begin
                            res0 = mk_res(EV_ERROR, 8'd0, ERR_ENTITY, d_now, upd_line, upd_col);
                        end
                        else
                        begin
                            res0 = mk_res(EV_TEXT_END, 8'd0, ERR_NONE, d_now, upd_line, upd_col);
                        end
                        res_cnt = 2'd1;
                    end
                    else if (!ent_open_reg)
                    begin
                        if (c == CH_AMP)
                        begin
                            ent_open_next = 1'b1;
                            ent_cnt_next  = '0;
                            ent_mask_next = '1;
                        end
                        else
                        begin
                            res0    = mk_res(EV_TEXT, c, ERR_NONE, d_now, upd_line, upd_col);
                            res_cnt = 2'd1;
                        end
                    end
                    else if (ent_hit)
                    begin
                        ent_open_next = 1'b0;
                        ent_cnt_next  = '0;
                        res0          = mk_res(EV_TEXT, ent_char, ERR_NONE, d_now,
                                               upd_line, upd_col);
                        res_cnt       = 2'd1;
                    end
                    else if (!ent_any)
                    begin
                        res0    = mk_res(EV_ERROR, 8'd0, ERR_ENTITY, d_now, upd_line, upd_col);
                        res_cnt = 2'd1;
                    end
                    else
                    begin
                        ent_cnt_next  = ent_cnt_reg + 3'd1;
                        ent_mask_next = ent_mask_new;
                    end
                end
                S_END:
                begin
                    if (nest_reg == '0)
                    begin
                        if (c == CH_GT)
                        begin
                            res0 = mk_res(EV_ERROR, 8'd0, ERR_MISMATCH, d_now, upd_line, upd_col);
                            res_cnt = 2'd1;
                        end
                    end
                    else if (c == CH_GT)
                    begin
                        if (end_ok)
                        begin
                            nest_next    = nest_reg - NW'(1);
                            top_len_next = len_rdata;
                            res0 = mk_res(EV_END_ELEM, 8'd0, ERR_NONE, d_down, upd_line, upd_col);
                        end
                        else
                        begin
                            res0 = mk_res(EV_ERROR, 8'd0, ERR_MISMATCH, d_now, upd_line, upd_col);
                        end
                        res_cnt = 2'd1;
                    end
                    else if (end_match)
                    begin
                        idx_next = idx_reg + LW'(1);
                    end
                    else
                    begin
                        mism_next = 1'b1;
                    end
                end
                S_EXCLMIN, S_MIN, S_MIN2:
                begin
                    if (((state_reg == S_MIN2) && (c != CH_GT))
                        || ((state_reg != S_MIN2) && (c != CH_MINUS)))
                    begin
                        res0    = mk_res(EV_ERROR, 8'd0, ERR_COMMENT, d_now, upd_line, upd_col);
                        res_cnt = 2'd1;
                    end
                end
                S_CDEND, S_CDEND2:
                begin
                    if (((state_reg == S_CDEND2) && (c != CH_GT))
                        || ((state_reg == S_CDEND) && (c != CH_RBRK)))
                    begin
                        res0    = mk_res(EV_ERROR, 8'd0, ERR_CDATA, d_now, upd_line, upd_col);
                        res_cnt = 2'd1;
                    end
                end
                default:
                begin
                    res_cnt = 2'd0;
                end
            endcase
        end
    end

    // Reads are prefetched for the state that the next byte will see.
    always_comb
    begin
        nest_eff  = take ? nest_next : nest_reg;
        idx_eff   = take ? idx_next : idx_reg;
        idx_clamp = (idx_eff >= NAME_FULL) ? NAW'(MAX_NAME - 1) : NAW'(idx_eff);
        stk_raddr = AW'(DW'(nest_eff - NW'(1))) * ROW + AW'(idx_clamp);
        len_raddr = DW'(nest_eff - NW'(2));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            nest_reg     <= '0;
            top_len_reg  <= '0;
            idx_reg      <= '0;
            mism_reg     <= 1'b0;
            ent_open_reg <= 1'b0;
            ent_cnt_reg  <= '0;
            ent_mask_reg <= '0;
            line_reg     <= LINE_W'(1);
            col_reg      <= COL_W'(1);
        end
        else if (take)
        begin
            state_reg    <= state_next;
            nest_reg     <= nest_next;
            top_len_reg  <= top_len_next;
            idx_reg      <= idx_next;
            mism_reg     <= mism_next;
            ent_open_reg <= ent_open_next;
            ent_cnt_reg  <= ent_cnt_next;
            ent_mask_reg <= ent_mask_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
        end
    end

    xbt_name_store #(
        .AW (AW),
        .DW (DW),
        .LW (LW)
    ) u_store (
        .clk       (clk),
        .stk_we    (stk_we && take),
        .stk_waddr (stk_waddr),
        .stk_wdata (c),
        .stk_raddr (stk_raddr),
        .stk_rdata (stk_rdata),
        .len_we    (len_we && take),
        .len_waddr (top_idx),
        .len_wdata (top_len_reg),
        .len_raddr (len_raddr),
        .len_rdata (len_rdata)
    );
endmodule
`default_nettype wire

// ===== sv/xbt_out_buf.sv =====
// Result register holding the one or two results of a byte for the output stream.
`default_nettype none
module xbt_out_buf (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          load,
    input  xbt_pkg::res_t      res0,
    input  xbt_pkg::res_t      res1,
    input  wire logic [1:0]    res_cnt,
    output logic               free,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [63:0]        m_tdata,   // event_kind, data_byte, error_code, depth, line_no, col_no
    output logic               m_tlast
);
    import xbt_pkg::*;

    logic   valid_reg;
    logic   two_reg;
    logic   ptr_reg;
    res_t   r0_reg, r1_reg;

    assign m_tvalid = valid_reg;
    assign m_tlast  = two_reg ? ptr_reg : 1'b1;
    assign m_tdata  = pack_res(ptr_reg ? r1_reg : r0_reg);
    assign free     = !valid_reg || (m_tready && m_tlast);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            two_reg   <= 1'b0;
            ptr_reg   <= 1'b0;
        end
        else if (free)
        begin
            valid_reg <= load && (res_cnt != 2'd0);
            two_reg   <= res_cnt == 2'd2;
            ptr_reg   <= 1'b0;
        end
        else if (m_tready)
        begin
            ptr_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (free && load)
        begin
            r0_reg <= res0;
            r1_reg <= res1;
        end
    end
endmodule
`default_nettype wire

// ===== sv/xml_byte_tokenizer_top.sv =====
// Top level of the streaming XML byte tokenizer.
// Usage: document bytes arrive one per transfer on the slave stream (s_tdata[7:0]);
// byte 0 ends the document, yields a doc end event and restarts the parser.
// Each byte causes zero, one or two events on the master stream; m_tlast marks
// the final event caused by a byte. Events carry the kind, the byte (decoded
// for text entities), an error number, the nesting depth and line and column.
// An accepted byte is held in the input register and parsed from there; its events
// are loaded into the result register and offered from it.
// Throughput: one byte per cycle while each byte gives at most one event and the
// receiver is ready; a byte that gives two events (a self-closing tag) holds the input
// until its last event is taken, as the result register hands out one event per cycle.
// The name stack is a memory whose read is prefetched for the next byte, so an end
// tag is checked one byte per cycle while the result register is free, with no read stall.
// After an error the parser is halted and drops bytes until byte 0.
// Reset clears all control state; stack memory contents need no clearing.
// When the receiver stalls, the pending event holds, the input register takes
// one more byte, and s_tready then falls until the event is taken.
`default_nettype none
module xml_byte_tokenizer_top #(
    parameter int MAX_DEPTH = 16,
    parameter int MAX_NAME  = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // doc_byte
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [63:0]      m_tdata,   // event_kind, data_byte, error_code, depth, line_no, col_no
    output logic             m_tlast    // last
);
    import xbt_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       buf_free;
    logic       take;
    res_t       res0, res1;
    logic [1:0] res_cnt;

    // The parser takes the held byte whenever the result register can accept its events.
    assign take     = in_valid_reg && buf_free;
    assign s_tready = !in_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
        end
    end

    xbt_parser #(
        .MAX_DEPTH (MAX_DEPTH),
        .MAX_NAME  (MAX_NAME)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .byte_in (in_byte_reg),
        .res0    (res0),
        .res1    (res1),
        .res_cnt (res_cnt)
    );

    xbt_out_buf u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (take),
        .res0     (res0),
        .res1     (res1),
        .res_cnt  (res_cnt),
        .free     (buf_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );
endmodule
`default_nettype wire

// ===== sv/xbt_checker.sv =====
// Port-level checks of the tokenizer output stream and their binding.
`default_nettype none
module xbt_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [63:0] m_tdata,
    input wire logic        m_tlast
);
    import xbt_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled event changed");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[3:0] <= EV_DOC_END)
        else $error("event kind out of range");

    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[3:0] != EV_ERROR) |-> m_tdata[15:12] == ERR_NONE)
        else $error("error code on a non-error event");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && ((m_tdata[3:0] == EV_DOC_END) || (m_tdata[3:0] == EV_ERROR))
        |-> m_tlast)
        else $error("doc end or error not final");

    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[40:21] != 20'd0) && (m_tdata[56:41] != 16'd0))
        else $error("position zero");
endmodule

bind xml_byte_tokenizer_top xbt_checker u_xbt_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
`default_nettype wire

// ===== bench/tb_xml_byte_tokenizer_top.sv =====
// Self-checking testbench of the streaming XML byte tokenizer.
`timescale 1ns / 100ps
`default_nettype none
module tb_xml_byte_tokenizer_top;
    import xbt_pkg::*;

    localparam int DEPTH_MAX  = 16;
    localparam int NAME_MAX   = 32;
    localparam int STALL_LIMIT = 2000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // doc_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // event_kind, data_byte, error_code, depth, line_no, col_no
    logic        m_tlast;   // last

    xml_byte_tokenizer_top u_top (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    // One expected event: the packed event fields and the last flag.
    typedef struct packed {
        res_t ev;
        logic lst;
    } event_exp_t;

    event_exp_t   expected_events[$];
    int           error_count = 0;
    int           idle_cycles = 0;
    int           ready_hold = 0;
    bit           gaps_on = 1;
    bit           watchdog_off = 0;

    // Shadow copy of the parser state.
    parse_state_t ps;
    int           nest;
    logic [7:0]   names [DEPTH_MAX][NAME_MAX];
    int           name_len [DEPTH_MAX];
    int           end_idx;
    bit           end_bad;
    logic [7:0]   ent_buf [5];
    int           ent_cnt;
    bit           ent_on;
    logic [LINE_W-1:0] line_cnt;
    logic [COL_W-1:0]  col_cnt;
    event_exp_t   step_events[$];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic bit ws_char(input logic [7:0] c);
        return c == CH_SPACE || c == CH_LF || c == CH_TAB || c == CH_CR;
    endfunction

    function automatic void clear_parser();
        ps = S_IDLE;
        nest = 0;
        end_idx = 0;
        end_bad = 0;
        ent_cnt = 0;
        ent_on = 0;
        line_cnt = 1;
        col_cnt = 1;
    endfunction

    // Records one event with the current depth and position; at most two per byte.
    function automatic void emit(input ev_kind_t k, input logic [7:0] d, input err_code_t e);
        event_exp_t x;
        if (step_events.size() >= 2)
            return;
        x.ev.kind = k;
        x.ev.data = d;
        x.ev.err = e;
        x.ev.depth = nest[4:0];
        x.ev.line = line_cnt;
        x.ev.col = col_cnt;
        x.lst = 1'b0;
        step_events = {step_events, x};
    endfunction

    function automatic void halt_with(input err_code_t e);
        emit(EV_ERROR, 8'h00, e);
        ps = S_HALT;
    endfunction

    function automatic void open_tag(input logic [7:0] c);
        if (c == CH_GT || ws_char(c))
        begin
            halt_with(ERR_NO_NAME);
            return;
        end
        if (nest >= DEPTH_MAX)
        begin
            halt_with(ERR_CAPACITY);
            return;
        end
        names[nest][0] = c;
        name_len[nest] = 1;
        nest++;
        ps = S_START;
        emit(EV_NAME, c, ERR_NONE);
    endfunction

    function automatic void close_self();
        emit(EV_START_DONE, 8'h00, ERR_NONE);
        if (nest > 0)
            nest--;
        emit(EV_END_ELEM, 8'h00, ERR_NONE);
        ps = S_SELF;
    endfunction

    function automatic void enter_content();
        emit(EV_START_DONE, 8'h00, ERR_NONE);
        ps = S_CONTENT;
        ent_on = 0;
        ent_cnt = 0;
    endfunction

    // Text byte with entity decoding; errors are flagged on the first impossible byte.
    function automatic void text_char(input logic [7:0] c);
        bit any_match;
        bit ok;
        if (!ent_on)
        begin
            if (c == CH_AMP)
            begin
                ent_on = 1;
                ent_cnt = 0;
            end
            else
                emit(EV_TEXT, c, ERR_NONE);
            return;
        end
        if (ent_cnt >= 5)
        begin
            halt_with(ERR_ENTITY);
            return;
        end
        ent_buf[ent_cnt] = c;
        ent_cnt++;
        any_match = 0;
        for (int k = 0; k < ENT_NUM; k++)
        begin
            ok = ent_cnt <= ENT_LEN[k];
            for (int i = 0; i < ent_cnt; i++)
                if (ok && ent_buf[i] != ENT_PAT[k][8*i +: 8])
                    ok = 0;
            if (ok)
            begin
                any_match = 1;
                if (ent_cnt == ENT_LEN[k])
                begin
                    ent_on = 0;
                    ent_cnt = 0;
                    emit(EV_TEXT, ENT_VAL[k], ERR_NONE);
                    return;
                end
            end
        end
        if (!any_match)
            halt_with(ERR_ENTITY);
    endfunction

    function automatic void end_tag_char(input logic [7:0] c);
        int top;
        if (nest == 0)
        begin
            if (c == CH_GT)
                halt_with(ERR_MISMATCH);
            return;
        end
        top = nest - 1;
        if (c == CH_GT)
        begin
            if (end_bad || end_idx != name_len[top])
            begin
                halt_with(ERR_MISMATCH);
                return;
            end
            nest--;
            emit(EV_END_ELEM, 8'h00, ERR_NONE);
            ps = S_IDLE;
            return;
        end
        if (end_bad || end_idx >= name_len[top] || names[top][end_idx] != c)
            end_bad = 1;
        else
            end_idx++;
    endfunction

    // Advances the shadow parser by one byte and queues the events it causes.
    function automatic void predict_byte(input logic [7:0] c);
        step_events.delete();
        if (c == CH_NUL)
        begin
            emit(EV_DOC_END, 8'h00, ERR_NONE);
            clear_parser();
        end
        else if (ps != S_HALT)
        begin
            if (col_cnt != COL_SAT)
                col_cnt++;
            if (c == CH_LF)
            begin
                if (line_cnt != LINE_SAT)
                    line_cnt++;
                col_cnt = 1;
            end
            case (ps)
                S_IDLE:
                    if (c == CH_LT) ps = S_LT;
                    else if (!ws_char(c)) halt_with(ERR_OUTSIDE);
                S_LT:
                    if (c == CH_SLASH)
                    begin
                        end_idx = 0; end_bad = 0; ps = S_END;
                    end
                    else if (c == CH_EXCL) ps = S_EXCL;
                    else if (c == CH_QUEST) ps = S_QUEST;
                    else open_tag(c);
                S_QUEST:
                    if (c == CH_QUEST) ps = S_QUEST2;
                S_QUEST2:
                    if (c == CH_GT) ps = S_IDLE; else halt_with(ERR_PROLOG);
                S_START:
                    if (c == CH_SLASH) close_self();
                    else if (c == CH_GT) enter_content();
                    else if (ws_char(c)) ps = S_ATT;
                    else if (name_len[nest-1] >= NAME_MAX) halt_with(ERR_CAPACITY);
                    else
                    begin
                        names[nest-1][name_len[nest-1]] = c;
                        name_len[nest-1]++;
                        emit(EV_NAME, c, ERR_NONE);
                    end
                S_ATT:
                    if (ws_char(c)) ;
                    else if (c == CH_GT) enter_content();
                    else if (c == CH_SLASH) close_self();
                    else
                    begin
                        ps = S_ATTNAME;
                        emit(EV_ATTR_NAME, c, ERR_NONE);
                    end
                S_ATTNAME:
                    if (c == CH_EQ) ps = S_ATTEQ; else emit(EV_ATTR_NAME, c, ERR_NONE);
                S_ATTEQ:
                    if (c == CH_QUOTE) ps = S_ATTVAL; else halt_with(ERR_ATTR);
                S_ATTVAL:
                    if (c == CH_QUOTE) ps = S_ATT; else emit(EV_ATTR_VAL, c, ERR_NONE);
                S_SELF:
                    if (c == CH_GT) ps = S_IDLE; else halt_with(ERR_SLASH);
                S_CONTENT:
                    if (c == CH_LT)
                    begin
                        if (ent_on) halt_with(ERR_ENTITY);
                        else
                        begin
                            emit(EV_TEXT_END, 8'h00, ERR_NONE);
                            ps = S_NEWTAG;
                        end
                    end
                    else text_char(c);
                S_END: end_tag_char(c);
                S_NEWTAG:
                    if (c == CH_SLASH)
                    begin
                        end_idx = 0; end_bad = 0; ps = S_END;
                    end
                    else if (c == CH_EXCL) ps = S_EXCL;
                    else open_tag(c);
                S_EXCL:
                    if (c == CH_LBRK) ps = S_CDSTART;
                    else if (c == CH_MINUS) ps = S_EXCLMIN;
                S_EXCLMIN:
                    if (c == CH_MINUS) ps = S_COMMENT; else halt_with(ERR_COMMENT);
                S_COMMENT:
                    if (c == CH_MINUS) ps = S_MIN;
                S_MIN:
                    if (c == CH_MINUS) ps = S_MIN2; else halt_with(ERR_COMMENT);
                S_MIN2:
                    if (c == CH_GT) ps = S_IDLE; else halt_with(ERR_COMMENT);
                S_CDSTART:
                    if (c == CH_LBRK) ps = S_CDATA;
                S_CDATA:
                    if (c == CH_RBRK) ps = S_CDEND;
                S_CDEND:
                    if (c == CH_RBRK) ps = S_CDEND2; else halt_with(ERR_CDATA);
                S_CDEND2:
                    if (c == CH_GT) ps = S_IDLE; else halt_with(ERR_CDATA);
                default: ps = S_HALT;
            endcase
        end
        if (step_events.size() > 0)
            step_events[step_events.size()-1].lst = 1'b1;
        foreach (step_events[i])
            expected_events = {expected_events, step_events[i]};
    endfunction

    // Sends one byte, with an occasional random gap before it.
    task automatic send_byte(input logic [7:0] b);
        if (gaps_on && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do
            @(posedge clk);
        while (!s_tready);
        predict_byte(b);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Waits for every expected event, then for the pipeline to settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Receiver side: drops m_tready in random bursts while gaps are on.
    always @(posedge clk)
        if (!rst_n)
            m_tready <= 1'b0;
        else if (gaps_on && ready_hold > 0)
        begin
            ready_hold <= ready_hold - 1;
            m_tready   <= 1'b0;
        end
        else if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            ready_hold <= $urandom_range(0, 4);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;

    // Compares every event transfer with the oldest expectation.
    always @(posedge clk)
    begin
        event_exp_t want;
        res_t       got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = res_t'(m_tdata[$bits(res_t)-1:0]);
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected event, expected none, actual %h last %b",
                         $realtime, m_tdata, m_tlast);
                error_count++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (got !== want.ev || m_tdata[63:$bits(res_t)] !== '0 || m_tlast !== want.lst)
                begin
                    $display("%0t: event mismatch, expected %h last %b, actual %h last %b",
                             $realtime, want.ev, want.lst, got, m_tlast);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: counts cycles without any transfer.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || watchdog_off)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic test_well_formed();
        send_text("<?xml v?>\n<a x=\"1\" y=\"\">t&amp;&lt;&gt;&quot;&apos;<b/></a>");
        send_text(" <!-- c - x --><![CDATA[ ] ]]>");
        send_byte(CH_NUL);
    endtask

    task automatic test_error_cases();
        send_text("x");          send_byte(8'hFF); send_byte(CH_NUL);
        send_text("<?a?b");      send_byte(CH_NUL);
        send_text("< ");         send_byte(CH_NUL);
        send_text("<>");         send_byte(CH_NUL);
        send_text("<a b=1");     send_byte(CH_NUL);
        send_text("<a/x");       send_byte(CH_NUL);
        send_text("<a>&ax");     send_byte(CH_NUL);
        send_text("<a>&amp<");   send_byte(CH_NUL);
        send_text("<a></b>");    send_byte(CH_NUL);
        send_text("</a>");       send_byte(CH_NUL);
        send_text("<!-x");       send_byte(CH_NUL);
        send_text("<!--a-b");    send_byte(CH_NUL);
        send_text("<![x[a]b");   send_byte(CH_NUL);
        send_text("<![[a]]x");   send_byte(CH_NUL);
        send_text("<a></a><");   send_byte(CH_NUL);
    endtask

    task automatic test_capacity();
        for (int i = 0; i <= DEPTH_MAX; i++)
            send_text("<n>");
        send_byte(CH_NUL);
        send_byte(CH_LT);
        for (int i = 0; i <= NAME_MAX; i++)
            send_byte(8'h80 + i[7:0]);
        send_byte(CH_NUL);
    endtask

    // Mostly well-formed documents with random names, attributes and text.
    task automatic test_random_docs(input int n_bytes);
        int    sent;
        string tags[$];
        string nm;
        int    r;
        sent = 0;
        while (sent < n_bytes)
        begin
            tags.delete();
            send_text("<?p?>");
            for (int e = 0; e < $urandom_range(1, 12); e++)
            begin
                r = $urandom_range(0, 9);
                if (r < 4 && tags.size() < DEPTH_MAX)
                begin
                    nm = "";
                    for (int k = 0; k < $urandom_range(1, 4); k++)
                        nm = {nm, string'(8'($urandom_range(8'h61, 8'h7A)))};
                    send_text({"<", nm});
                    if ($urandom_range(0, 1))
                        send_text(" k=\"v\x81\"");
                    if ($urandom_range(0, 3) == 0)
                        send_text("/>");
                    else
                    begin
                        send_text(">");
                        tags = {tags, nm};
                    end
                end
                else if (r < 7 && tags.size() > 0)
                    send_text({"</", tags.pop_back(), ">"});
                else if (r == 7 && tags.size() > 0)
                    send_text("x\n&gt;y");
                else if (r == 8)
                    send_text("<!--z-->");
                else
                    send_byte(8'($urandom_range(1, 255)));
                sent += 6;
            end
            while (tags.size() > 0)
                send_text({"</", tags.pop_back(), ">"});
            if ($urandom_range(0, 3) == 0)
                send_byte(8'($urandom_range(0, 255)));
            send_byte(CH_NUL);
            sent += 10;
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = 8'h00;
        clear_parser();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_well_formed();
        test_error_cases();
        test_capacity();
        // The sender holds off here until every event has been taken.
        drain();
        test_random_docs(1500);
        gaps_on = 0;
        test_random_docs(300);
        drain();
        watchdog_off = 1;
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
